// ===== rtl/core/gas_pkg.sv =====
`timescale 1ns / 1ps
// Package for the greedy activity selection unit.
// Holds default sizes, the result number width and the controller/datapath structs.
// No dependencies.
package gas_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int unsigned MaxActivitiesDef = 64;
  localparam int unsigned TimeWidthDef     = 16;

  // Width of the one-based activity number on the result port.
  localparam int unsigned NumW = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // store the accepted item
    logic scan_init;  // restart a search pass over the stored activities
    logic scan_run;   // search pass in progress
    logic decide;     // take the outcome of a finished search pass
  } gas_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;   // all stored activities have been examined
    logic best_found;  // the pass found an eligible activity
  } gas_sts_t;

endpackage

// ===== rtl/core/greedy_activity_selection_unit.sv =====
`timescale 1ns / 1ps
// Top level of the greedy activity selection unit (earliest finish first).
// Depends on gas_pkg, gas_ctrl, gas_dpath and gas_ram.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+--------------------------------------------
//   input   | start_i high, busy_o low  | start_time_i, finish_time_i, last_item_i
//   result  | valid_o high, one cycle   | activity_number_o, chosen_start_o,
//           |                           | chosen_finish_o, final_choice_o, overflowed_o
//
// Loading accepts an item whenever start_i is high and busy_o is low; items beyond
// capacity are dropped and reported on overflowed_o.
// The item with last_item_i starts the selection. Each chosen activity costs one
// search pass over the n stored activities through the store's single read port,
// and one closing pass finds none left; busy_o stays high until that pass ends.
// Reset clears the set and the controller; the store needs no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module greedy_activity_selection_unit #(
  parameter int unsigned MAX_ACTIVITIES = gas_pkg::MaxActivitiesDef,
  parameter int unsigned TIME_WIDTH     = gas_pkg::TimeWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [TIME_WIDTH-1:0]    start_time_i,
  input  logic [TIME_WIDTH-1:0]    finish_time_i,
  input  logic                     last_item_i,
  output logic                     valid_o,
  output logic [gas_pkg::NumW-1:0] activity_number_o,
  output logic [TIME_WIDTH-1:0]    chosen_start_o,
  output logic [TIME_WIDTH-1:0]    chosen_finish_o,
  output logic                     final_choice_o,
  output logic                     overflowed_o
);
  import gas_pkg::*;

  gas_cmd_t cmd;
  gas_sts_t sts;

  // Sequencer.
  gas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .last_item_i (last_item_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  // Store, search and result register.
  gas_dpath #(
    .MAX_ACTIVITIES (MAX_ACTIVITIES),
    .TIME_WIDTH     (TIME_WIDTH)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_time_i      (start_time_i),
    .finish_time_i     (finish_time_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .valid_o           (valid_o),
    .activity_number_o (activity_number_o),
    .chosen_start_o    (chosen_start_o),
    .chosen_finish_o   (chosen_finish_o),
    .final_choice_o    (final_choice_o),
    .overflowed_o      (overflowed_o)
  );

endmodule

// ===== rtl/core/gas_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/gas_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the greedy activity selection unit.
// Depends on gas_pkg for the command and status structs.
module gas_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             last_item_i,
  input  gas_pkg::gas_sts_t sts_i,
  output gas_pkg::gas_cmd_t cmd_o,
  output logic             busy_o
);
  import gas_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StDecide = 2'd2;

  logic [1:0] state_q, state_d;
  logic       take;

  assign busy_o = (state_q != StIdle);
  assign take   = start_i && !busy_o;

  // Commands follow directly from the state, the handshake and the datapath status.
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = take;
    cmd_o.scan_init = (take && last_item_i) ||
                      (state_q == StDecide && sts_i.best_found);
    cmd_o.scan_run  = (state_q == StScan);
    cmd_o.decide    = (state_q == StDecide);
  end

  // Next state: a set is searched once per chosen activity, plus one closing pass.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (take && last_item_i) state_d = StScan;
      end
      StScan: begin
        if (sts_i.scan_done) state_d = StDecide;
      end
      StDecide: begin
        state_d = sts_i.best_found ? StScan : StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/gas_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the greedy activity selection unit: activity store, search pass
// and result register. Depends on gas_pkg and gas_ram.
module gas_dpath #(
  parameter int unsigned MAX_ACTIVITIES = gas_pkg::MaxActivitiesDef,
  parameter int unsigned TIME_WIDTH     = gas_pkg::TimeWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [TIME_WIDTH-1:0]     start_time_i,
  input  logic [TIME_WIDTH-1:0]     finish_time_i,
  input  gas_pkg::gas_cmd_t         cmd_i,
  output gas_pkg::gas_sts_t         sts_o,
  output logic                      valid_o,
  output logic [gas_pkg::NumW-1:0]  activity_number_o,
  output logic [TIME_WIDTH-1:0]     chosen_start_o,
  output logic [TIME_WIDTH-1:0]     chosen_finish_o,
  output logic                      final_choice_o,
  output logic                      overflowed_o
);
  import gas_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ACTIVITIES);
  localparam int unsigned CW = $clog2(MAX_ACTIVITIES + 1);
  localparam int unsigned DW = 2 * TIME_WIDTH;

  // Control state.
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          pipe_vld_q, pipe_vld_d;
  logic          best_found_q, best_found_d;
  logic          have_pend_q, have_pend_d;
  logic          valid_q, valid_d;

  // Payload state.
  logic [AW-1:0]         pipe_idx_q, pipe_idx_d;
  logic [AW-1:0]         best_idx_q, best_idx_d;
  logic [TIME_WIDTH-1:0] best_start_q, best_start_d;
  logic [TIME_WIDTH-1:0] best_fin_q, best_fin_d;
  logic [AW-1:0]         pend_idx_q, pend_idx_d;
  logic [TIME_WIDTH-1:0] pend_start_q, pend_start_d;
  logic [TIME_WIDTH-1:0] pend_fin_q, pend_fin_d;
  logic [NumW-1:0]       out_num_q, out_num_d;
  logic [TIME_WIDTH-1:0] out_start_q, out_start_d;
  logic [TIME_WIDTH-1:0] out_fin_q, out_fin_d;
  logic                  out_final_q, out_final_d;
  logic                  out_ovf_q, out_ovf_d;

  logic          not_full;
  logic          issue;
  logic [DW-1:0] rd_data;
  logic [TIME_WIDTH-1:0] d_start, d_fin;
  logic          after_pend, eligible, better;
  logic [CW-1:0] pend_num;

  assign not_full = (count_q < CW'(MAX_ACTIVITIES));
  assign issue    = cmd_i.scan_run && (rd_idx_q < count_q);

  // Start and finish of every stored activity; its number is its address plus one.
  gas_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ACTIVITIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && not_full),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({start_time_i, finish_time_i}),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign d_start = rd_data[DW-1:TIME_WIDTH];
  assign d_fin   = rd_data[TIME_WIDTH-1:0];

  // An activity follows the last chosen one in sorted order when its finish is
  // later, or equal with a later arrival; ties in the search keep the earliest.
  assign after_pend = (d_fin > pend_fin_q) ||
                      ((d_fin == pend_fin_q) && (pipe_idx_q > pend_idx_q));
  assign eligible   = !have_pend_q || (after_pend && (d_start >= pend_fin_q));
  assign better     = !best_found_q || (d_fin < best_fin_q);

  assign pend_num = CW'(pend_idx_q) + CW'(1);

  assign sts_o.scan_done  = (rd_idx_q == count_q) && !pipe_vld_q;
  assign sts_o.best_found = best_found_q;

  // Next-state logic for loading, searching and emitting.
  always_comb begin
    count_d      = count_q;
    ovf_d        = ovf_q;
    rd_idx_d     = rd_idx_q;
    pipe_vld_d   = 1'b0;
    pipe_idx_d   = rd_idx_q[AW-1:0];
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_start_d = best_start_q;
    best_fin_d   = best_fin_q;
    have_pend_d  = have_pend_q;
    pend_idx_d   = pend_idx_q;
    pend_start_d = pend_start_q;
    pend_fin_d   = pend_fin_q;
    valid_d      = 1'b0;
    out_num_d    = out_num_q;
    out_start_d  = out_start_q;
    out_fin_d    = out_fin_q;
    out_final_d  = out_final_q;
    out_ovf_d    = out_ovf_q;

    // Loading: store while there is room, otherwise note the drop.
    if (cmd_i.load) begin
      if (not_full) begin
        count_d = count_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end

    // Search pass: one read issued and one stored activity examined per cycle.
    if (cmd_i.scan_run) begin
      if (issue) begin
        rd_idx_d   = rd_idx_q + CW'(1);
        pipe_vld_d = 1'b1;
      end
      if (pipe_vld_q && eligible && better) begin
        best_found_d = 1'b1;
        best_idx_d   = pipe_idx_q;
        best_start_d = d_start;
        best_fin_d   = d_fin;
      end
    end

    // End of a pass: the previous choice goes out, the new one is held back
    // until it is known whether another follows.
    if (cmd_i.decide) begin
      if (have_pend_q) begin
        valid_d     = 1'b1;
        out_num_d   = NumW'(pend_num);
        out_start_d = pend_start_q;
        out_fin_d   = pend_fin_q;
        out_final_d = !best_found_q;
        out_ovf_d   = ovf_q;
      end
      if (best_found_q) begin
        have_pend_d  = 1'b1;
        pend_idx_d   = best_idx_q;
        pend_start_d = best_start_q;
        pend_fin_d   = best_fin_q;
      end else begin
        have_pend_d = 1'b0;
        count_d     = '0;
        ovf_d       = 1'b0;
      end
    end

    if (cmd_i.scan_init) begin
      rd_idx_d     = '0;
      pipe_vld_d   = 1'b0;
      best_found_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      ovf_q        <= 1'b0;
      rd_idx_q     <= '0;
      pipe_vld_q   <= 1'b0;
      best_found_q <= 1'b0;
      have_pend_q  <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      count_q      <= count_d;
      ovf_q        <= ovf_d;
      rd_idx_q     <= rd_idx_d;
      pipe_vld_q   <= pipe_vld_d;
      best_found_q <= best_found_d;
      have_pend_q  <= have_pend_d;
      valid_q      <= valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pipe_idx_q   <= pipe_idx_d;
    best_idx_q   <= best_idx_d;
    best_start_q <= best_start_d;
    best_fin_q   <= best_fin_d;
    pend_idx_q   <= pend_idx_d;
    pend_start_q <= pend_start_d;
    pend_fin_q   <= pend_fin_d;
    out_num_q    <= out_num_d;
    out_start_q  <= out_start_d;
    out_fin_q    <= out_fin_d;
    out_final_q  <= out_final_d;
    out_ovf_q    <= out_ovf_d;
  end

  assign valid_o           = valid_q;
  assign activity_number_o = out_num_q;
  assign chosen_start_o    = out_start_q;
  assign chosen_finish_o   = out_fin_q;
  assign final_choice_o    = out_final_q;
  assign overflowed_o      = out_ovf_q;

endmodule

// ===== rtl/core/gas_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the greedy activity selection unit, and the bind that
// attaches them. Depends on greedy_activity_selection_unit.
module gas_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic last_item_i,
  input logic valid_o,
  input logic final_choice_o
);

  // The item that closes a set always starts a selection.
  a_last_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_item_i |=> busy_o)
    else $error("closing item did not start a selection");

  // An ordinary item is only stored or dropped and leaves the unit ready.
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !last_item_i |=> !busy_o)
    else $error("ordinary item made the unit busy");

  // Results are separated by at least one search pass.
  a_no_adjacent_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("two results in adjacent cycles");

  // A result that is not the last of its run means the selection goes on.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !final_choice_o |-> busy_o)
    else $error("run ended without a final result");

endmodule

bind greedy_activity_selection_unit gas_checker u_gas_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .last_item_i    (last_item_i),
  .valid_o        (valid_o),
  .final_choice_o (final_choice_o)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for greedy_activity_selection_unit: loads activity sets,
// predicts the earliest-finish selection and checks every chosen activity.
// Depends on gas_pkg and the RTL of the unit.
module tb;
  import gas_pkg::*;

  localparam int unsigned TW  = TimeWidthDef;
  localparam int unsigned CAP = MaxActivitiesDef;

  // One chosen activity as the unit should report it.
  typedef struct packed {
    logic [NumW-1:0] number;
    logic [TW-1:0]   begin_t;
    logic [TW-1:0]   end_t;
    logic            last_pick;
    logic            dropped;
  } choice_t;

  // Keeps its own copy of the loaded set and the queue of selections still owed.
  class activity_scoreboard;
    logic [TW-1:0]   start_mem[CAP];
    logic [TW-1:0]   finish_mem[CAP];
    int unsigned     loaded;
    logic            ovf;
    choice_t         chosen_q[$];
    int unsigned     errors;

    function new();
      loaded = 0;
      ovf    = 1'b0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return chosen_q.size();
    endfunction

    // Stable sort by finish time, then the greedy pick over the sorted order.
    function void select_earliest_finish();
      int      order[CAP];
      int      i;
      int      j;
      int      pos;
      int      prev;
      choice_t picks[$];
      choice_t c;
      for (i = 0; i < loaded; i++) order[i] = i;
      for (i = 1; i < loaded; i++) begin
        pos = order[i];
        j   = i;
        while (j > 0 && finish_mem[order[j-1]] > finish_mem[pos]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = pos;
      end
      prev = order[0];
      for (i = 0; i < loaded; i++) begin
        pos = order[i];
        if (i == 0 || start_mem[pos] >= finish_mem[prev]) begin
          c.number    = NumW'(pos + 1);
          c.begin_t   = start_mem[pos];
          c.end_t     = finish_mem[pos];
          c.last_pick = 1'b0;
          c.dropped   = ovf;
          picks.push_back(c);
          prev = pos;
        end
      end
      picks[picks.size()-1].last_pick = 1'b1;
      foreach (picks[k]) chosen_q.push_back(picks[k]);
    endfunction

    // An accepted item: store it or drop it, and run the selection on the last one.
    function void note_item(logic [TW-1:0] s, logic [TW-1:0] f, logic last);
      if (loaded < CAP) begin
        start_mem[loaded]  = s;
        finish_mem[loaded] = f;
        loaded++;
      end else begin
        ovf = 1'b1;
      end
      if (!last) return;
      if (loaded > 0) select_earliest_finish();
      loaded = 0;
      ovf    = 1'b0;
    endfunction

    // A result from the unit against the oldest selection still owed.
    function void check_result(logic [NumW-1:0] num, logic [TW-1:0] s, logic [TW-1:0] f,
                               logic fin, logic dr);
      choice_t e;
      if (chosen_q.size() == 0) begin
        $display("%0t: unexpected result number %0d start %0d finish %0d",
                 $time, num, s, f);
        errors++;
        return;
      end
      e = chosen_q.pop_front();
      if (num !== e.number) begin
        $display("%0t: activity_number expected %0d actual %0d", $time, e.number, num);
        errors++;
      end
      if (s !== e.begin_t) begin
        $display("%0t: chosen_start expected %0d actual %0d", $time, e.begin_t, s);
        errors++;
      end
      if (f !== e.end_t) begin
        $display("%0t: chosen_finish expected %0d actual %0d", $time, e.end_t, f);
        errors++;
      end
      if (fin !== e.last_pick) begin
        $display("%0t: final_choice expected %0b actual %0b", $time, e.last_pick, fin);
        errors++;
      end
      if (dr !== e.dropped) begin
        $display("%0t: overflowed expected %0b actual %0b", $time, e.dropped, dr);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            start_i;
  logic            busy_o;
  logic [TW-1:0]   start_time_i;
  logic [TW-1:0]   finish_time_i;
  logic            last_item_i;
  logic            valid_o;
  logic [NumW-1:0] activity_number_o;
  logic [TW-1:0]   chosen_start_o;
  logic [TW-1:0]   chosen_finish_o;
  logic            final_choice_o;
  logic            overflowed_o;

  activity_scoreboard sb;
  int unsigned        sent;

  greedy_activity_selection_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .start_time_i      (start_time_i),
    .finish_time_i     (finish_time_i),
    .last_item_i       (last_item_i),
    .valid_o           (valid_o),
    .activity_number_o (activity_number_o),
    .chosen_start_o    (chosen_start_o),
    .chosen_finish_o   (chosen_finish_o),
    .final_choice_o    (final_choice_o),
    .overflowed_o      (overflowed_o)
  );

  // Clock, 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Monitor: notes each accepted item and checks each result at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_item(start_time_i, finish_time_i, last_item_i);
      if (valid_o) sb.check_result(activity_number_o, chosen_start_o, chosen_finish_o,
                                   final_choice_o, overflowed_o);
    end
  end

  // Drives one item after an idle gap and holds it until the unit takes it.
  task automatic send_item(logic [TW-1:0] s, logic [TW-1:0] f, logic last, int gap);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i       = 1'b1;
    start_time_i  = s;
    finish_time_i = f;
    last_item_i   = last;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    sent++;
  endtask

  // Holds the sender off until every owed selection has come out.
  task automatic wait_drained();
    start_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Mostly back to back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Sends one random set of n items; the last marker goes on the final item.
  task automatic send_random_set(int n);
    bit            burst;
    bit            tight;
    logic [TW-1:0] s;
    logic [TW-1:0] f;
    burst = ($urandom_range(0, 3) == 0);
    tight = ($urandom_range(0, 1) == 0);
    for (int i = 0; i < n; i++) begin
      if (tight) begin
        // Narrow range so that ties and touching intervals are common.
        s = TW'($urandom_range(0, 40));
        f = ($urandom_range(0, 4) == 0) ? TW'($urandom_range(0, 40))
                                        : s + TW'($urandom_range(0, 12));
      end else begin
        s = TW'($urandom);
        f = TW'($urandom);
      end
      send_item(s, f, (i == n - 1), pick_gap(burst));
    end
  endtask

  // Watchdog.
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // Main sequence.
  initial begin
    int r;
    int n;
    int set_idx;
    sb            = new();
    sent          = 0;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    start_time_i  = '0;
    finish_time_i = '0;
    last_item_i   = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Single activities at both ends of the time range.
    send_item('0, '0, 1'b1, 0);
    send_item('1, '1, 1'b1, 2);
    send_item('0, '1, 1'b1, 0);

    // Equal finishes, start equal to the previous finish, start after finish.
    send_item(16'd5, 16'd10, 1'b0, 0);
    send_item(16'd0, 16'd10, 1'b0, 0);
    send_item(16'd10, 16'd10, 1'b0, 1);
    send_item(16'd10, 16'd20, 1'b0, 0);
    send_item(16'd20, 16'd20, 1'b0, 0);
    send_item(16'd20, 16'hFFFF, 1'b0, 0);
    send_item(16'hFFFF, 16'd0, 1'b1, 0);
    wait_drained();

    // Classic overlapping schedule.
    send_item(16'd1, 16'd4, 1'b0, 0);
    send_item(16'd3, 16'd5, 1'b0, 0);
    send_item(16'd0, 16'd6, 1'b0, 0);
    send_item(16'd5, 16'd7, 1'b0, 3);
    send_item(16'd3, 16'd9, 1'b0, 0);
    send_item(16'd5, 16'd9, 1'b0, 0);
    send_item(16'd6, 16'd10, 1'b0, 0);
    send_item(16'd8, 16'd11, 1'b0, 0);
    send_item(16'd8, 16'd12, 1'b0, 0);
    send_item(16'd2, 16'd14, 1'b0, 0);
    send_item(16'd12, 16'd16, 1'b1, 0);

    // Random sets: first an overfull one and an exactly full one, then mostly small.
    set_idx = 0;
    while (sent < 460) begin
      r = $urandom_range(0, 99);
      if (set_idx == 0 || r < 2) n = CAP + $urandom_range(1, 4);
      else if (set_idx == 1 || r < 4) n = CAP;
      else if (r < 25) n = $urandom_range(9, 24);
      else n = $urandom_range(1, 8);
      send_random_set(n);
      if ($urandom_range(0, 9) == 0) wait_drained();
      set_idx++;
    end

    // Drain, then wait so that any unexpected extra result is caught.
    wait_drained();
    repeat (150) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== greedy_activity_selection_unit.f =====
rtl/core/gas_pkg.sv
rtl/core/gas_ram.sv
rtl/core/gas_ctrl.sv
rtl/core/gas_dpath.sv
rtl/core/greedy_activity_selection_unit.sv
rtl/core/gas_checker.sv
dv/tb.sv
